FILE: rtl/lfu_pkg.sv
package lfu_pkg;

    localparam int CAPACITY   = 16;
    localparam int COUNT_BITS = 16;
    localparam int KEY_W      = 32;
    localparam int VAL_W      = 32;
    localparam int CFG_W      = 5;
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int FILL_W     = $clog2(CAPACITY + 1);

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // Contents of one cache line.
    typedef struct packed {
        logic                  valid;
        logic [KEY_W-1:0]      key;
        logic [VAL_W-1:0]      value;
        logic [COUNT_BITS-1:0] count;
    } entry_t;

    // Victim candidate handed along the row of cells.
    typedef struct packed {
        logic                  valid;
        logic [COUNT_BITS-1:0] count;
        logic [IDX_W-1:0]      pos;
        logic [KEY_W-1:0]      key;
    } cand_t;

endpackage

FILE: rtl/lfu_cell.sv
module lfu_cell
    import lfu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] pos,
    input  logic [KEY_W-1:0] req_key,
    input  logic             load,
    input  entry_t           din,
    input  cand_t            best_in,
    output entry_t           q,
    output logic             match,
    output cand_t            best_out
);

    logic                  valid_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [VAL_W-1:0]      value_reg;
    logic [COUNT_BITS-1:0] count_reg;
    cand_t                 best_reg;
    cand_t                 best_next;
    logic                  own_better;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= din.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            key_reg   <= din.key;
            value_reg <= din.value;
            count_reg <= din.count;
        end
        best_reg <= best_next;
    end

    // Incoming candidates are older, so an equal count keeps the incoming one.
    always_comb
    begin
        own_better = valid_reg && (!best_in.valid || (count_reg < best_in.count));
        if (own_better)
        begin
            best_next = '{valid: 1'b1, count: count_reg, pos: pos, key: key_reg};
        end
        else
        begin
            best_next = best_in;
        end
    end

    assign q        = '{valid: valid_reg, key: key_reg, value: value_reg, count: count_reg};
    assign match    = valid_reg && (key_reg == req_key);
    assign best_out = best_reg;

endmodule

FILE: rtl/lfu_cache_table.sv
// Least-frequently-used key/value cache with least-recently-used tie break.
// Requests arrive on the s_ channel: s_tuser carries the command (get or put),
// s_tdata the key and the value. Each request produces exactly one item on
// the m_ channel: m_tuser holds the hit and evicted flags, m_tdata the read
// value and the evicted key.
// Entries sit in a row of cells kept in recency order, cell 0 being the most
// recent. A touched, inserted or replacing entry moves to cell 0 while the
// cells in front of its old place each shift back by one.
// The victim search hands a candidate from the oldest cell towards the front,
// one cell a cycle. After acceptance the search runs, then the row is updated
// and the result registered; no new item is taken before the result is registered.
// The capacity register is written through cfg_we/cfg_data; write it only
// while idle, as the block itself does not enforce this. Values above
// CAPACITY act as CAPACITY and zero disables inserts.
// Reset empties the table and sets the capacity to sixteen.
// A result waits in its output register while the receiver stalls; the next
// item is still accepted and searched, but the row is not updated until the
// pending result has been taken.
module lfu_cache_table
    import lfu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [63:0]          s_tdata,  // key [31:0], value [63:32]
    input  logic                 s_tuser,  // cmd
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [63:0]          m_tdata,  // read_value [31:0], evicted_key [63:32]
    output logic [1:0]           m_tuser   // hit [0], evicted [1]
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_APPLY  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]  cap_reg;
    logic [FILL_W-1:0] filled_reg;
    logic [FILL_W-1:0] wait_reg;
    logic              cmd_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [VAL_W-1:0]  value_reg;
    logic              out_valid_reg;
    logic [63:0]       out_data_reg;
    logic [1:0]        out_user_reg;

    entry_t            cell_q    [CAPACITY];
    entry_t            cell_din  [CAPACITY];
    cand_t             cell_best [CAPACITY];
    cand_t             cell_bin  [CAPACITY];
    logic [CAPACITY-1:0] cell_load;
    logic [CAPACITY-1:0] match_vec;

    logic [FILL_W-1:0]     cap_eff;
    logic                  hit;
    logic [IDX_W-1:0]      hit_pos;
    logic [VAL_W-1:0]      hit_value;
    logic [COUNT_BITS-1:0] hit_count;
    logic                  cap_on;
    logic                  need_evict;
    logic                  commit;
    logic [FILL_W-1:0]     move_pos;
    entry_t                front;
    logic                  apply_go;
    logic [VAL_W-1:0]      rd_value;
    logic                  ev;

    // The row of cells: each one takes its neighbour's entry on a shift.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == 0)
        begin : g_front
            assign cell_din[i] = front;
        end
        else
        begin : g_rest
            assign cell_din[i] = cell_q[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_tail
            assign cell_bin[i] = '0;
        end
        else
        begin : g_mid
            assign cell_bin[i] = cell_best[i+1];
        end
        assign cell_load[i] = apply_go && commit && (FILL_W'(i) <= move_pos);

        lfu_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .pos      (IDX_W'(i)),
            .req_key  (key_reg),
            .load     (cell_load[i]),
            .din      (cell_din[i]),
            .best_in  (cell_bin[i]),
            .q        (cell_q[i]),
            .match    (match_vec[i]),
            .best_out (cell_best[i])
        );
    end

    // Keys are unique among valid cells, so the matches can be merged by OR.
    always_comb
    begin
        hit_pos   = '0;
        hit_value = '0;
        hit_count = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (match_vec[i])
            begin
                hit_pos   = hit_pos | IDX_W'(i);
                hit_value = hit_value | cell_q[i].value;
                hit_count = hit_count | cell_q[i].count;
            end
        end
    end

    assign hit     = |match_vec;
    assign cap_eff = (32'(cap_reg) > CAPACITY) ? FILL_W'(CAPACITY) : FILL_W'(cap_reg);
    assign cap_on  = (cap_eff != '0);
    assign need_evict = (cmd_reg == CMD_PUT) && cap_on && !hit &&
                        (filled_reg >= cap_eff) && (filled_reg != '0);
    assign commit  = hit ? ((cmd_reg == CMD_GET) || cap_on) :
                           ((cmd_reg == CMD_PUT) && cap_on);
    assign ev      = need_evict && cell_best[0].valid;

    always_comb
    begin
        priority if (hit)
        begin
            move_pos = FILL_W'(hit_pos);
        end
        else if (need_evict)
        begin
            move_pos = FILL_W'(cell_best[0].pos);
        end
        else
        begin
            move_pos = filled_reg;
        end
    end

    always_comb
    begin
        if (hit)
        begin
            front.valid = 1'b1;
            front.key   = key_reg;
            front.value = (cmd_reg == CMD_PUT) ? value_reg : hit_value;
            front.count = (hit_count == {COUNT_BITS{1'b1}}) ? hit_count :
                          hit_count + COUNT_BITS'(1);
        end
        else
        begin
            front.valid = 1'b1;
            front.key   = key_reg;
            front.value = value_reg;
            front.count = COUNT_BITS'(1);
        end
    end

    always_comb
    begin
        if (cmd_reg == CMD_GET)
        begin
            rd_value = hit ? hit_value : {VAL_W{1'b1}};
        end
        else
        begin
            rd_value = '0;
        end
    end

    assign apply_go = (state_reg == ST_APPLY) && (!out_valid_reg || m_tready);
    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (wait_reg == FILL_W'(CAPACITY - 1))
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (apply_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CFG_W'(16);
            filled_reg    <= '0;
            wait_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            if (state_reg == ST_SEARCH)
            begin
                wait_reg <= wait_reg + FILL_W'(1);
            end
            else
            begin
                wait_reg <= '0;
            end
            if (apply_go)
            begin
                out_valid_reg <= 1'b1;
                if (commit && !hit && !need_evict)
                begin
                    filled_reg <= filled_reg + FILL_W'(1);
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg   <= s_tuser;
            key_reg   <= s_tdata[31:0];
            value_reg <= s_tdata[63:32];
        end
        if (apply_go)
        begin
            out_data_reg <= {(ev ? cell_best[0].key : {KEY_W{1'b0}}), rd_value};
            out_user_reg <= {ev, hit};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(filled_reg) <= CAPACITY)
        else $error("fill count beyond the number of cells");

    a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_APPLY) |-> $onehot0(match_vec))
        else $error("key present in more than one cell");

    a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("eviction reported on a hit");

    a_accept_search: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_SEARCH))
        else $error("accepted item did not start a search");

endmodule

FILE: tb/tb.sv
module tb;
    import lfu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Expected outcome of one cache request, in the order requests were accepted.
    typedef struct {
        logic             hit;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
    } lookup_result_t;

    // Scoreboard: carries its own copy of the table and the capacity setting, works out
    // the result of every accepted request, and checks arriving results in order.
    class cache_scoreboard;
        bit                    line_valid [CAPACITY];
        logic [KEY_W-1:0]      line_key   [CAPACITY];
        logic [VAL_W-1:0]      line_value [CAPACITY];
        logic [COUNT_BITS-1:0] line_count [CAPACITY];
        int                    line_age   [CAPACITY];
        int                    occupancy;
        int                    capacity;
        lookup_result_t        pending[$];
        int                    errors;
        int                    hits;
        int                    evictions;

        function void clear();
            for (int i = 0; i < CAPACITY; i++)
            begin
                line_valid[i] = 0;
                line_age[i] = 0;
            end
            occupancy = 0;
            capacity = 16;
        endfunction

        // Make one line the most recent; younger lines age by one.
        function void promote(int s);
            for (int i = 0; i < CAPACITY; i++)
                if (line_valid[i] && i != s && line_age[i] < line_age[s])
                    line_age[i]++;
            line_age[s] = 0;
        endfunction

        function void note_request(logic cmd, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
            lookup_result_t r;
            int s;
            int cap;
            int vic;
            int f;
            s = -1;
            vic = -1;
            f = -1;
            cap = (capacity > CAPACITY) ? CAPACITY : capacity;
            for (int i = CAPACITY - 1; i >= 0; i--)
                if (line_valid[i] && line_key[i] == k)
                    s = i;
            r.hit = (s >= 0);
            r.read_value = '0;
            r.evicted = 0;
            r.evicted_key = '0;
            if (cmd == CMD_GET)
            begin
                if (s >= 0)
                begin
                    if (line_count[s] != '1)
                        line_count[s]++;
                    promote(s);
                    r.read_value = line_value[s];
                end
                else
                    r.read_value = '1;
            end
            else if (cap != 0)
            begin
                if (s >= 0)
                begin
                    line_value[s] = v;
                    if (line_count[s] != '1)
                        line_count[s]++;
                    promote(s);
                end
                else
                begin
                    if (occupancy >= cap && occupancy > 0)
                    begin
                        for (int i = 0; i < CAPACITY; i++)
                        begin
                            if (!line_valid[i])
                                continue;
                            if (vic < 0 || line_count[i] < line_count[vic] ||
                                (line_count[i] == line_count[vic] &&
                                 line_age[i] > line_age[vic]))
                                vic = i;
                        end
                        for (int i = 0; i < CAPACITY; i++)
                            if (line_valid[i] && line_age[i] > line_age[vic])
                                line_age[i]--;
                        line_valid[vic] = 0;
                        occupancy--;
                        r.evicted = 1;
                        r.evicted_key = line_key[vic];
                    end
                    for (int i = CAPACITY - 1; i >= 0; i--)
                        if (!line_valid[i])
                            f = i;
                    if (f >= 0)
                    begin
                        for (int j = 0; j < CAPACITY; j++)
                            if (line_valid[j])
                                line_age[j]++;
                        line_valid[f] = 1;
                        line_key[f] = k;
                        line_value[f] = v;
                        line_count[f] = 1;
                        line_age[f] = 0;
                        occupancy++;
                    end
                end
            end
            hits += r.hit;
            evictions += r.evicted;
            pending.push_back(r);
        endfunction

        function void check_result(logic [1:0] flags, logic [63:0] data);
            lookup_result_t e;
            if (pending.size() == 0)
            begin
                $error("result arrived with nothing outstanding");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (flags[0] !== e.hit)
            begin
                $error("hit: expected %0d, actual %0d", e.hit, flags[0]);
                errors++;
            end
            if (data[31:0] !== e.read_value)
            begin
                $error("read_value: expected %h, actual %h", e.read_value, data[31:0]);
                errors++;
            end
            if (flags[1] !== e.evicted)
            begin
                $error("evicted: expected %0d, actual %0d", e.evicted, flags[1]);
                errors++;
            end
            if (data[63:32] !== e.evicted_key)
            begin
                $error("evicted_key: expected %h, actual %h", e.evicted_key, data[63:32]);
                errors++;
            end
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 20000;
    // Settling time after the last result; allow generous margin at the end.
    localparam int DRAIN_CYCLES   = 4 * (CAPACITY + 3);

    logic             clk = 0;
    logic             rst_n = 0;
    logic             cfg_we = 0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             s_tvalid = 0;
    logic             s_tready;
    logic [63:0]      s_tdata = '0;
    logic             s_tuser = 0;
    logic             m_tvalid;
    logic             m_tready = 0;
    logic [63:0]      m_tdata;
    logic [1:0]       m_tuser;

    // Idle and stall percentages, changed from phase to phase.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int idle_cycles = 0;
    int requests_sent = 0;
    cache_scoreboard sb;

    always #4 clk = ~clk;

    lfu_cache_table u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_we  (cfg_we),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // Receiver side: the ready line is redrawn every cycle, and results are
    // checked on the edge at which they are taken.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tdata);
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog over cycles in which neither channel moves an item.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("lfu_cache_table test failed");
            $finish;
        end
    end

    // Present one request and hold it until the block accepts it. Idle gaps
    // are drawn before the item, so they fall anywhere in the block's work.
    // The block is never ready in the cycle after an acceptance, so the valid
    // line is dropped before the next request.
    task automatic send_request(logic cmd, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct)
            @(posedge clk);
        s_tvalid <= 1;
        s_tuser <= cmd;
        s_tdata <= {v, k};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(cmd, k, v);
        requests_sent++;
        s_tvalid <= 0;
        @(posedge clk);
    endtask

    // Wait until every expected result has arrived, then let the block settle.
    task automatic wait_drained();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // The capacity may only change while nothing is in flight.
    task automatic set_capacity(logic [CFG_W-1:0] c);
        wait_drained();
        cfg_we <= 1;
        cfg_data <= c;
        @(posedge clk);
        cfg_we <= 0;
        sb.capacity = c;
    endtask

    task automatic random_phase(int n, int pool_span);
        logic [KEY_W-1:0] k;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) == 0)
                k = $urandom();
            else
                k = 32'h100 + $urandom_range(pool_span - 1);
            send_request(1'($urandom_range(1)), k, $urandom());
        end
    endtask

    initial
    begin
        sb = new();
        sb.clear();
        sb.errors = 0;
        sb.hits = 0;
        sb.evictions = 0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed part: extreme keys and values, miss, hit, update, eviction.
        send_request(CMD_GET, 32'h8000_0000, 32'h0);
        send_request(CMD_PUT, 32'h8000_0000, 32'h7fff_ffff);
        send_request(CMD_PUT, 32'h7fff_ffff, 32'h8000_0000);
        send_request(CMD_PUT, 32'hffff_ffff, 32'hffff_ffff);
        send_request(CMD_PUT, 32'h0, 32'h0);
        send_request(CMD_GET, 32'h8000_0000, 32'h1234_5678);
        send_request(CMD_GET, 32'hffff_ffff, 32'h0);
        send_request(CMD_PUT, 32'h7fff_ffff, 32'h5555_aaaa);
        send_request(CMD_GET, 32'h7fff_ffff, 32'h0);
        // Capacity of two: the absent key pushes out the least used entry.
        set_capacity(CFG_W'(2));
        send_request(CMD_PUT, 32'h0000_0042, 32'h1);
        send_request(CMD_PUT, 32'h0000_0043, 32'h2);
        send_request(CMD_GET, 32'h0000_0042, 32'h0);
        send_request(CMD_PUT, 32'h0000_0044, 32'h3);
        // Capacity zero: puts leave the table alone, gets still work.
        set_capacity(CFG_W'(0));
        send_request(CMD_PUT, 32'h0000_0045, 32'h4);
        send_request(CMD_PUT, 32'h0000_0042, 32'h5);
        send_request(CMD_GET, 32'h0000_0042, 32'h0);
        // Capacity above the table size saturates; single-entry capacity.
        set_capacity(CFG_W'(31));
        send_request(CMD_PUT, 32'h0000_0046, 32'h6);
        set_capacity(CFG_W'(1));
        send_request(CMD_PUT, 32'h0000_0047, 32'h7);
        send_request(CMD_GET, 32'h0000_0047, 32'h0);

        // Hold the sender until every outstanding result has come back.
        wait_drained();

        // Random phases across idling patterns and capacity settings.
        set_capacity(CFG_W'(16));
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_phase(300, 24);
        set_capacity(CFG_W'(4));
        send_idle_pct = 61;
        recv_stall_pct = 0;
        random_phase(300, 8);
        set_capacity(CFG_W'(9));
        send_idle_pct = 0;
        recv_stall_pct = 61;
        random_phase(300, 14);
        set_capacity(CFG_W'(0));
        send_idle_pct = 11;
        recv_stall_pct = 11;
        random_phase(50, 14);
        set_capacity(CFG_W'(16));
        random_phase(200, 20);
        // Hammer one key long enough to exercise heavy reuse counts.
        set_capacity(CFG_W'(3));
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 150; i++)
            send_request(1'($urandom_range(1)),
                         (i % 3 == 0) ? 32'h0000_0200 + 32'(i) : 32'h0000_0101,
                         $urandom());

        wait_drained();
        $display("Covered %0d requests with %0d hits and %0d evictions,", requests_sent,
                 sb.hits, sb.evictions);
        $display("over capacities 0, 1, 2, 3, 4, 9, 16 and 31 with varied idling.");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("lfu_cache_table test passed");
        else
            $display("lfu_cache_table test failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/lfu_pkg.sv
rtl/lfu_cell.sv
rtl/lfu_cache_table.sv
tb/tb.sv
